// ----- src/cistercian_glyph_row_generator_macros.svh -----
// ---------------------------------------------------------------------------
// Cistercian glyph row generator assertion macros
// Shared property forms for the checks at the end of the block's modules.
// ---------------------------------------------------------------------------
`ifndef CISTERCIAN_GLYPH_ROW_GENERATOR_MACROS_SVH
`define CISTERCIAN_GLYPH_ROW_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CGR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CGR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/cgr_pkg.sv -----
// ---------------------------------------------------------------------------
// Cistercian glyph row generator package
// Shared types, constants and the stroke rendering functions.
// ---------------------------------------------------------------------------
package cgr_pkg;

	localparam int CGR_QUEUE_DEPTH = 4;

	localparam int GLYPH_W   = 20;
	localparam int STEM_ROWS = 31;
	localparam int STROKE    = 8;

	// Reciprocal multipliers, exact for all 14-bit values.
	localparam int RECIP10   = 6554;   // 2^16 / 10, rounded up
	localparam int RECIP100  = 10486;  // 2^20 / 100, rounded up
	localparam int RECIP1000 = 16778;  // 2^24 / 1000, rounded up

	// Quadrant placement: horizontal stroke x, vertical stroke x,
	// outer edge row, inner row, and top row of the diagonal block.
	localparam int RIGHT_XH  = 10;
	localparam int RIGHT_XV  = 16;
	localparam int LEFT_XH   = 0;
	localparam int LEFT_XV   = 0;
	localparam int TOP_EDGE  = 0;
	localparam int TOP_IN    = 8;
	localparam int TOP_BLK   = 0;
	localparam int BOT_EDGE  = 29;
	localparam int BOT_IN    = 21;
	localparam int BOT_BLK   = 21;

	typedef struct packed {
		logic [3:0] d0;
		logic [3:0] d1;
		logic [3:0] d2;
		logic [3:0] d3;
		logic [4:0] row;
	} cgr_item_t;

	typedef struct packed {
		logic      valid;
		cgr_item_t item;
	} cgr_req_t;

	function automatic logic [GLYPH_W-1:0] hline_row(int ox, int oy, int r);
		logic [GLYPH_W-1:0] m;
		m = '0;
		if (r == oy || r == oy + 1) begin
			m = GLYPH_W'(8'hFF) << ox;
		end
		return m;
	endfunction

	function automatic logic [GLYPH_W-1:0] vline_row(int ox, int oy, int r);
		logic [GLYPH_W-1:0] m;
		m = '0;
		if (r >= oy && r < oy + STROKE) begin
			m = GLYPH_W'(2'b11) << ox;
		end
		return m;
	endfunction

	// Each column of the diagonal covers three rows, stepping one row per column.
	function automatic logic [GLYPH_W-1:0] diag_row(int ox, int oy, int r, logic rising);
		logic [GLYPH_W-1:0] m;
		int top;
		m = '0;
		for (int i = 0; i < STROKE; i++) begin
			top = rising ? oy + (STROKE - 1 - i) : oy + i;
			if (r >= top && r <= top + 2) begin
				m = m | (GLYPH_W'(1'b1) << (ox + i));
			end
		end
		return m;
	endfunction

	function automatic logic [GLYPH_W-1:0] digit_row(logic [3:0] d, int xh, int xv,
			int yedge, int yin, int yblk, logic rise3, logic [4:0] row);
		logic [GLYPH_W-1:0] m;
		int r;
		r = int'(row);
		unique case (d)
			4'd1: m = hline_row(xh, yedge, r);
			4'd2: m = hline_row(xh, yin, r);
			4'd3: m = diag_row(xh, yblk, r, rise3);
			4'd4: m = diag_row(xh, yblk, r, !rise3);
			4'd5: m = hline_row(xh, yedge, r) | diag_row(xh, yblk, r, !rise3);
			4'd6: m = vline_row(xv, yblk, r);
			4'd7: m = hline_row(xh, yedge, r) | vline_row(xv, yblk, r);
			4'd8: m = hline_row(xh, yin, r) | vline_row(xv, yblk, r);
			4'd9: m = hline_row(xh, yedge, r) | hline_row(xh, yin, r)
				| vline_row(xv, yblk, r);
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// ----- src/cgr_front.sv -----
// ---------------------------------------------------------------------------
// Cistercian glyph row generator front end
// Accepts requests and splits the value into four decimal digits.
// ---------------------------------------------------------------------------
`include "cistercian_glyph_row_generator_macros.svh"

module cgr_front #(
	parameter int QDEPTH = cgr_pkg::CGR_QUEUE_DEPTH,
	localparam int CW = $clog2(QDEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [13:0]      value,
	input  logic [4:0]       row,
	input  logic [CW-1:0]    q_count,
	output logic             busy,
	output cgr_pkg::cgr_req_t push
);

	logic        valid_s1;
	logic [13:0] value_s1;
	logic [10:0] q1_s1;
	logic [7:0]  q2_s1;
	logic [4:0]  q3_s1;
	logic [4:0]  row_s1;
	logic        valid_s2;
	cgr_pkg::cgr_item_t item_s2;

	logic        accept;
	logic [26:0] p10;
	logic [27:0] p100;
	logic [28:0] p1000;
	logic [13:0] rem0;
	logic [10:0] rem1;
	logic [7:0]  rem2;
	logic [4:0]  rem3;
	cgr_pkg::cgr_item_t item_d;

	// Hold off new requests once the queue plus the items in flight would fill it.
	assign busy = ({1'b0, q_count} + (CW + 1)'(valid_s1) + (CW + 1)'(valid_s2))
		>= (CW + 1)'(QDEPTH);
	assign accept = start && !busy;

	assign p10   = 27'(value) * 27'(cgr_pkg::RECIP10);
	assign p100  = 28'(value) * 28'(cgr_pkg::RECIP100);
	assign p1000 = 29'(value) * 29'(cgr_pkg::RECIP1000);

	always_comb begin
		rem0 = value_s1 - 14'(q1_s1) * 14'd10;
		rem1 = q1_s1 - 11'(q2_s1) * 11'd10;
		rem2 = q2_s1 - 8'(q3_s1) * 8'd10;
		rem3 = (q3_s1 >= 5'd10) ? q3_s1 - 5'd10 : q3_s1;
		item_d.d0  = rem0[3:0];
		item_d.d1  = rem1[3:0];
		item_d.d2  = rem2[3:0];
		item_d.d3  = rem3[3:0];
		item_d.row = row_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= value;
			q1_s1    <= p10[26:16];
			q2_s1    <= p100[27:20];
			q3_s1    <= p1000[28:24];
			row_s1   <= row;
		end
		if (valid_s1) begin
			item_s2 <= item_d;
		end
	end

	assign push.valid = valid_s2;
	assign push.item  = item_s2;

	`CGR_ASSERT_NEXT(a_accept_enters, accept, valid_s1, "accepted request did not enter stage 1")
	`CGR_ASSERT_NEXT(a_s1_moves, valid_s1, valid_s2, "stage 1 item did not advance")
	`CGR_ASSERT_SAME(a_digits_decimal, valid_s2,
		item_s2.d0 <= 4'd9 && item_s2.d1 <= 4'd9 && item_s2.d2 <= 4'd9
		&& item_s2.d3 <= 4'd9, "digit split produced a non-decimal digit")

endmodule

// ----- src/cgr_queue.sv -----
// ---------------------------------------------------------------------------
// Cistercian glyph row generator queue
// Short FIFO of decoded requests between the front and back ends.
// ---------------------------------------------------------------------------
`include "cistercian_glyph_row_generator_macros.svh"

module cgr_queue #(
	parameter int QDEPTH = cgr_pkg::CGR_QUEUE_DEPTH,
	localparam int CW = $clog2(QDEPTH + 1),
	localparam int PW = $clog2(QDEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cgr_pkg::cgr_req_t push,
	output cgr_pkg::cgr_req_t pop,
	output logic [CW-1:0]     count
);

	cgr_pkg::cgr_item_t regs_q [QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	// The back end never stalls, so a stored request leaves on the next cycle.
	assign do_pop = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push.valid) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			regs_q[wptr_q] <= push.item;
		end
	end

	assign pop.valid = do_pop;
	assign pop.item  = regs_q[rptr_q];
	assign count     = count_q;

	`CGR_ASSERT_SAME(a_no_overflow, push.valid && count_q == CW'(QDEPTH), do_pop,
		"request pushed into a full queue")
	`CGR_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(QDEPTH),
		"queue count beyond its depth")
	`CGR_ASSERT_NEXT(a_push_stored, push.valid && !do_pop, count_q != '0,
		"pushed request was not stored")

endmodule

// ----- src/cgr_back.sv -----
// ---------------------------------------------------------------------------
// Cistercian glyph row generator back end
// Renders one glyph row from the four digits and registers the result.
// ---------------------------------------------------------------------------
`include "cistercian_glyph_row_generator_macros.svh"

module cgr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cgr_pkg::cgr_req_t pop,
	output logic              done,
	output logic [19:0]       row_mask
);

	logic        done_q;
	logic [19:0] mask_q;
	logic [19:0] mask_d;

	always_comb begin
		mask_d = '0;
		if (int'(pop.item.row) < cgr_pkg::STEM_ROWS) begin
			mask_d = 20'h00300;
		end
		mask_d = mask_d
			| cgr_pkg::digit_row(pop.item.d0, cgr_pkg::RIGHT_XH, cgr_pkg::RIGHT_XV,
				cgr_pkg::TOP_EDGE, cgr_pkg::TOP_IN, cgr_pkg::TOP_BLK, 1'b0, pop.item.row)
			| cgr_pkg::digit_row(pop.item.d1, cgr_pkg::LEFT_XH, cgr_pkg::LEFT_XV,
				cgr_pkg::TOP_EDGE, cgr_pkg::TOP_IN, cgr_pkg::TOP_BLK, 1'b1, pop.item.row)
			| cgr_pkg::digit_row(pop.item.d2, cgr_pkg::RIGHT_XH, cgr_pkg::RIGHT_XV,
				cgr_pkg::BOT_EDGE, cgr_pkg::BOT_IN, cgr_pkg::BOT_BLK, 1'b1, pop.item.row)
			| cgr_pkg::digit_row(pop.item.d3, cgr_pkg::LEFT_XH, cgr_pkg::LEFT_XV,
				cgr_pkg::BOT_EDGE, cgr_pkg::BOT_IN, cgr_pkg::BOT_BLK, 1'b1, pop.item.row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pop.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop.valid) begin
			mask_q <= mask_d;
		end
	end

	assign done     = done_q;
	assign row_mask = mask_q;

	`CGR_ASSERT_NEXT(a_pop_done, pop.valid, done, "popped request gave no result")
	`CGR_ASSERT_NEXT(a_no_spurious, !pop.valid, !done, "result without a request")
	`CGR_ASSERT_SAME(a_margin_blank, done, row_mask[19:18] == 2'b00,
		"ink in the right margin")

endmodule

// ----- src/cistercian_glyph_row_generator.sv -----
// ---------------------------------------------------------------------------
// Cistercian glyph row generator
// Returns one 20-pixel row of the Cistercian numeral glyph for a value.
// ---------------------------------------------------------------------------
// The block takes one request per clock and returns each row mask from the
// render register, strobed by done for exactly one cycle. Results cannot be
// held off, so the render stage drains the queue every cycle and, at the
// default QDEPTH, busy stays low under any request pattern; the rate is one
// row per clock, set by the render stage behind the two-stage digit split.

module cistercian_glyph_row_generator #(
	parameter int QDEPTH = cgr_pkg::CGR_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [13:0] value,
	input  logic [4:0]  row,
	output logic        done,
	output logic [19:0] row_mask
);

	localparam int CW = $clog2(QDEPTH + 1);

	cgr_pkg::cgr_req_t push;
	cgr_pkg::cgr_req_t pop;
	logic [CW-1:0]     q_count;

	cgr_front #(.QDEPTH(QDEPTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.value   (value),
		.row     (row),
		.q_count (q_count),
		.busy    (busy),
		.push    (push)
	);

	cgr_queue #(.QDEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.count  (q_count)
	);

	cgr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.done     (done),
		.row_mask (row_mask)
	);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Cistercian glyph row generator testbench
// A driver feeds row requests from a queue with random gaps. A monitor
// predicts each row mask at acceptance and compares the strobed results in
// order.
// ---------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic [13:0] value;
		logic [4:0]  row;
		bit          drain;
	} glyph_req_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic [13:0] value  = '0;
	logic [4:0]  row    = '0;
	logic        busy;
	logic        done;
	logic [19:0] row_mask;

	glyph_req_t  row_requests[$];
	logic [19:0] pending_masks[$];
	int          err_count = 0;
	bit          req_taken = 1'b0;
	int          gap_left  = 0;
	int          calm_left = 0;

	cistercian_glyph_row_generator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.row      (row),
		.done     (done),
		.row_mask (row_mask)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [19:0] hbar(int x, int y, int r);
		return (r == y || r == y + 1) ? (20'hFF << x) : 20'h0;
	endfunction

	function automatic logic [19:0] vbar(int x, int y, int r);
		return (r >= y && r < y + cgr_pkg::STROKE) ? (20'h3 << x) : 20'h0;
	endfunction

	// A rising stroke starts low on its left column and climbs one row per column.
	function automatic logic [19:0] slant(int x, int y, int r, bit rising);
		logic [19:0] m;
		int top;
		m = '0;
		for (int i = 0; i < cgr_pkg::STROKE; i++) begin
			top = rising ? y + cgr_pkg::STROKE - 1 - i : y + i;
			if (r >= top && r <= top + 2) begin
				m[x + i] = 1'b1;
			end
		end
		return m;
	endfunction

	function automatic logic [19:0] quadrant_mask(int d, int xh, int xv, int yedge, int yin,
			int yblk, bit rise3, int r);
		logic [19:0] m;
		m = '0;
		case (d)
			1: m = hbar(xh, yedge, r);
			2: m = hbar(xh, yin, r);
			3: m = slant(xh, yblk, r, rise3);
			4: m = slant(xh, yblk, r, !rise3);
			5: m = hbar(xh, yedge, r) | slant(xh, yblk, r, !rise3);
			6: m = vbar(xv, yblk, r);
			7: m = hbar(xh, yedge, r) | vbar(xv, yblk, r);
			8: m = hbar(xh, yin, r) | vbar(xv, yblk, r);
			9: m = hbar(xh, yedge, r) | hbar(xh, yin, r) | vbar(xv, yblk, r);
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [19:0] glyph_row_mask(logic [13:0] v, logic [4:0] rw);
		logic [19:0] m;
		int n;
		int r;
		n = int'(v);
		r = int'(rw);
		m = (r < cgr_pkg::STEM_ROWS) ? (20'h3 << 8) : 20'h0;
		m |= quadrant_mask(n % 10, cgr_pkg::RIGHT_XH, cgr_pkg::RIGHT_XV,
			cgr_pkg::TOP_EDGE, cgr_pkg::TOP_IN, cgr_pkg::TOP_BLK, 1'b0, r);
		m |= quadrant_mask(n / 10 % 10, cgr_pkg::LEFT_XH, cgr_pkg::LEFT_XV,
			cgr_pkg::TOP_EDGE, cgr_pkg::TOP_IN, cgr_pkg::TOP_BLK, 1'b1, r);
		m |= quadrant_mask(n / 100 % 10, cgr_pkg::RIGHT_XH, cgr_pkg::RIGHT_XV,
			cgr_pkg::BOT_EDGE, cgr_pkg::BOT_IN, cgr_pkg::BOT_BLK, 1'b1, r);
		m |= quadrant_mask(n / 1000 % 10, cgr_pkg::LEFT_XH, cgr_pkg::LEFT_XV,
			cgr_pkg::BOT_EDGE, cgr_pkg::BOT_IN, cgr_pkg::BOT_BLK, 1'b1, r);
		return m;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) begin
			return 0;
		end else if (k < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic push_req(int v, int r);
		glyph_req_t q;
		q.value = 14'(v);
		q.row   = 5'(r);
		q.drain = 1'b0;
		row_requests.push_back(q);
	endtask

	task automatic push_drain();
		glyph_req_t q;
		q.value = '0;
		q.row   = '0;
		q.drain = 1'b1;
		row_requests.push_back(q);
	endtask

	// Monitor: records accepted requests with their predicted mask and checks results.
	always @(posedge clk) begin
		logic [19:0] want;
		if (arst_n) begin
			req_taken = start && !busy;
			if (done) begin
				if (pending_masks.size() == 0) begin
					$error("row_mask: unexpected result, actual %05h", row_mask);
					err_count++;
				end else begin
					want = pending_masks.pop_front();
					if (row_mask !== want) begin
						$error("row_mask: expected %05h, actual %05h", want, row_mask);
						err_count++;
					end
				end
			end
			if (req_taken) begin
				pending_masks.push_back(glyph_row_mask(value, row));
			end
		end
	end

	// Driver: holds a request until it is taken, then idles or sends the next one.
	always @(negedge clk) begin
		glyph_req_t q;
		if (arst_n && !(start && !req_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (row_requests.size() == 0) begin
				start <= 1'b0;
			end else if (row_requests[0].drain) begin
				start <= 1'b0;
				if (pending_masks.size() == 0) begin
					q = row_requests.pop_front();
				end
			end else begin
				q = row_requests.pop_front();
				value <= q.value;
				row   <= q.row;
				start <= 1'b1;
				if (calm_left > 0) begin
					calm_left <= calm_left - 1;
					gap_left  <= 0;
				end else if ($urandom_range(0, 99) < 3) begin
					calm_left <= $urandom_range(20, 80);
					gap_left  <= 0;
				end else begin
					gap_left <= pick_gap();
				end
			end
		end
	end

	initial begin
		int n;
		int v;
		int len;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Every digit in every quadrant, blank and full values, the bottom row,
		// and values past four digits whose thousands digit wraps.
		push_req(0, 0);
		push_req(0, 30);
		push_req(0, 31);
		push_req(1111, 0);
		push_req(2222, 8);
		push_req(3333, 3);
		push_req(4444, 4);
		push_req(5555, 1);
		push_req(6666, 5);
		push_req(7777, 29);
		push_req(8888, 22);
		push_req(9999, 24);
		push_req(9999, 31);
		push_req(5555, 25);
		push_req(3333, 23);
		push_req(12345, 25);
		push_req(10000, 0);
		push_req(16383, 15);
		push_req(16383, 31);
		push_req(8421, 9);
		push_drain();

		n = 0;
		while (n < 1600) begin
			if ($urandom_range(0, 99) < 85) begin
				v = $urandom_range(0, 9999);
			end else begin
				v = $urandom_range(10000, 16383);
			end
			if ($urandom_range(0, 99) < 60) begin
				// A whole glyph, row by row.
				for (int r = 0; r < 32; r++) begin
					push_req(v, r);
				end
				n += 32;
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 85) begin
						v = $urandom_range(0, 9999);
					end else begin
						v = $urandom_range(0, 16383);
					end
					push_req(v, $urandom_range(0, 31));
				end
				n += len;
			end
			if (n % 400 < 32 && $urandom_range(0, 3) == 0) begin
				push_drain();
			end
		end

		while (row_requests.size() != 0 || start || pending_masks.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (err_count == 0 && pending_masks.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- cistercian_glyph_row_generator.f -----
+incdir+src
src/cgr_pkg.sv
src/cgr_front.sv
src/cgr_queue.sv
src/cgr_back.sv
src/cistercian_glyph_row_generator.sv
bench/tb_top.sv
